### hdl/hcbp_pkg.sv
// Shared types and constants for the Huffman code bit packer.
// No dependencies; imported by every module in hdl/.
package hcbp_pkg;

	// Default parameter values
	localparam int MAX_CODE_LEN_DEF = 32;
	localparam int SYMBOL_COUNT_DEF = 256;

	// Fixed field widths
	localparam int CMD_W   = 2;
	localparam int SYM_W   = 8;
	localparam int CODE_W  = 32;
	localparam int LEN_W   = 6;
	localparam int BYTE_W  = 8;
	localparam int ACC_W   = 7;
	localparam int CNT_W   = 3;
	// Pending bits plus one full code, left aligned
	localparam int ALIGN_W = ACC_W + CODE_W + 1;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD   = 2'd0,
		CMD_ENCODE = 2'd1,
		CMD_FLUSH  = 2'd2
	} cmd_code_t;

	// Input beat
	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [SYM_W-1:0]  symbol;
		logic [CODE_W-1:0] code_bits;
		logic [LEN_W-1:0]  code_length;
	} in_beat_t;

	// Output beat
	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              last;
	} out_beat_t;

	// Controller to datapath
	typedef struct packed {
		logic wr_entry;
		logic rd_entry;
		logic take_lookup;
		logic settle_lookup;
		logic load_flush;
		logic emit;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic is_load;
		logic is_encode;
		logic is_flush;
		logic in_range;
		logic count_zero;
		logic lookup_ge8;
		logic emit_last;
		logic out_free;
	} dp_stat_t;

endpackage

### hdl/hcbp_dp.sv
// Datapath: code table memory, bit accumulator, alignment and output register.
// Depends on hcbp_pkg.
module hcbp_dp import hcbp_pkg::*; #(
	parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF,
	parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  in_beat_t  code_item,
	input  logic      pack_stall,
	output logic      pack_valid,
	output out_beat_t pack_item,
	input  dp_cmd_t   cmd,
	output dp_stat_t  stat
);

	localparam int CODE_CAP = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
	localparam int IDX_W    = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
	localparam int TOT_W    = LEN_W;

	// Table entry: length and code bits left aligned (first bit in MSB)
	typedef struct packed {
		logic [LEN_W-1:0]  len;
		logic [CODE_W-1:0] bits;
	} entry_t;

	entry_t mem [SYMBOL_COUNT];
	entry_t rd_q;

	logic [ACC_W-1:0]   acc_q;
	logic [CNT_W-1:0]   count_q;
	logic [ALIGN_W-1:0] aligned_q;
	logic [TOT_W-1:0]   total_q;
	logic               out_valid_q;
	out_beat_t          out_q;

	logic [IDX_W-1:0]   idx;
	logic [LEN_W-1:0]   len_sat;
	entry_t             wr_entry;
	logic [ALIGN_W-1:0] aligned_c;
	logic [TOT_W-1:0]   total_c;
	logic [ALIGN_W-1:0] aligned_shift;
	logic [TOT_W-1:0]   total_rem;
	logic               last_c;

	// Incoming item decode
	assign idx = code_item.symbol[IDX_W-1:0];

	always_comb begin
		stat.is_load    = (code_item.command == CMD_LOAD);
		stat.is_encode  = (code_item.command == CMD_ENCODE);
		stat.is_flush   = (code_item.command == CMD_FLUSH);
		stat.in_range   = ({1'b0, code_item.symbol} < (SYM_W+1)'(SYMBOL_COUNT));
		stat.count_zero = (count_q == '0);
		stat.lookup_ge8 = (total_c >= TOT_W'(BYTE_W));
		stat.emit_last  = last_c;
		stat.out_free   = !out_valid_q || !pack_stall;
	end

	// Load: saturate length, left align code (stray high bits shift out)
	always_comb begin
		if (code_item.code_length > LEN_W'(CODE_CAP)) begin
			len_sat = LEN_W'(CODE_CAP);
		end else begin
			len_sat = code_item.code_length;
		end
		wr_entry.len  = len_sat;
		wr_entry.bits = code_item.code_bits << (LEN_W'(CODE_W) - len_sat);
	end

	// Code table: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.wr_entry) begin
			mem[idx] <= wr_entry;
		end
		if (cmd.rd_entry) begin
			rd_q <= mem[idx];
		end
	end

	// Append looked-up code behind the pending bits
	assign aligned_c = {acc_q, {(ALIGN_W-ACC_W){1'b0}}}
		| ({rd_q.bits, {(ALIGN_W-CODE_W){1'b0}}} >> count_q);
	assign total_c   = TOT_W'(count_q) + rd_q.len;

	// Byte emission from the top of the aligned word
	assign aligned_shift = aligned_q << BYTE_W;
	assign total_rem     = total_q - TOT_W'(BYTE_W);
	assign last_c        = (total_q < TOT_W'(2*BYTE_W));

	// Working word and count
	always_ff @(posedge clk) begin
		if (cmd.take_lookup) begin
			aligned_q <= aligned_c;
			total_q   <= total_c;
		end else if (cmd.load_flush) begin
			aligned_q <= {acc_q, {(ALIGN_W-ACC_W){1'b0}}};
			total_q   <= TOT_W'(BYTE_W);
		end else if (cmd.emit) begin
			aligned_q <= aligned_shift;
			total_q   <= total_rem;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.out_byte <= aligned_q[ALIGN_W-1 -: BYTE_W];
			out_q.last     <= last_c;
		end
	end

	// Accumulator and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.settle_lookup) begin
				acc_q   <= aligned_c[ALIGN_W-1 -: ACC_W];
				count_q <= total_c[CNT_W-1:0];
			end else if (cmd.emit && last_c) begin
				acc_q   <= aligned_shift[ALIGN_W-1 -: ACC_W];
				count_q <= total_rem[CNT_W-1:0];
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!pack_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign pack_valid = out_valid_q;
	assign pack_item  = out_q;

endmodule

### hdl/hcbp_ctrl.sv
// Controller state machine for the bit packer.
// Depends on hcbp_pkg; drives hcbp_dp through dp_cmd_t.
module hcbp_ctrl import hcbp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     code_valid,
	output logic     code_stall,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_LOOKUP = 3'b010,
		ST_EMIT   = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign code_stall = (state_q != ST_IDLE);
	assign accept     = code_valid && !code_stall;

	// Next state and datapath commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept && stat.in_range && stat.is_load) begin
					cmd.wr_entry = 1'b1;
				end
				if (accept && stat.in_range && stat.is_encode) begin
					cmd.rd_entry = 1'b1;
					state_d      = ST_LOOKUP;
				end
				if (accept && stat.is_flush && !stat.count_zero) begin
					cmd.load_flush = 1'b1;
					state_d        = ST_EMIT;
				end
			end
			ST_LOOKUP: begin
				if (stat.lookup_ge8) begin
					cmd.take_lookup = 1'b1;
					state_d         = ST_EMIT;
				end else begin
					cmd.settle_lookup = 1'b1;
					state_d           = ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					if (stat.emit_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### hdl/huffman_code_bit_packer_top.sv
// Channel    | Direction | Signals                              | Beat
// code input | in        | code_valid, code_stall, code_item    | in_beat_t
// byte out   | out       | pack_valid, pack_stall, pack_item    | out_beat_t
//
// Load writes a table entry. Flush emits a pending partial byte, if any. Encode
// emits up to 4 bytes after the lookup, paced by the single output register.
// arst_n clears the accumulator, the controller and the output valid; the
// code table is not cleared and each entry must be loaded before use.
// A stall on the byte output holds the emit state; input is stalled while busy.
// Top level of the Huffman code bit packer; depends on hcbp_pkg, hcbp_ctrl, hcbp_dp.
module huffman_code_bit_packer_top import hcbp_pkg::*; #(
	parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF,
	parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      code_valid,
	output logic      code_stall,
	input  in_beat_t  code_item,
	output logic      pack_valid,
	input  logic      pack_stall,
	output out_beat_t pack_item
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	hcbp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.code_valid (code_valid),
		.code_stall (code_stall),
		.stat       (stat),
		.cmd        (cmd)
	);

	hcbp_dp #(
		.MAX_CODE_LEN (MAX_CODE_LEN),
		.SYMBOL_COUNT (SYMBOL_COUNT)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.code_item  (code_item),
		.pack_stall (pack_stall),
		.pack_valid (pack_valid),
		.pack_item  (pack_item),
		.cmd        (cmd),
		.stat       (stat)
	);

endmodule

### bench/huffman_code_bit_packer_top_test.sv
// Self-checking bench for huffman_code_bit_packer_top: loads code table entries, encodes
// symbols and flushes, and checks every packed byte against an in-bench bit packer.
// Depends on hcbp_pkg and the RTL in hdl/.
module huffman_code_bit_packer_top_test;
	timeunit 1ns;
	timeprecision 1ps;
	import hcbp_pkg::*;

	localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;
	localparam int CODE_CAP    = (MAX_CODE_LEN_DEF < 32) ? MAX_CODE_LEN_DEF : 32;
	localparam int HOLD_CYCLES = 120;
	localparam int QUIET_LIMIT = 2000;
	localparam int TAIL_CYCLES = 20;

	typedef enum logic [1:0] {PH_RX_SLOW, PH_TX_SLOW, PH_FULL_RATE} idle_phase_t;

	// One queued input beat with its pacing flags
	typedef struct packed {
		in_beat_t    beat;
		idle_phase_t phase;
		logic        drain;
		logic        hold;
	} code_req_t;

	logic      clk        = 1'b0;
	logic      arst_n     = 1'b0;
	logic      code_valid = 1'b0;
	logic      code_stall;
	in_beat_t  code_item  = '0;
	logic      pack_valid;
	logic      pack_stall = 1'b0;
	out_beat_t pack_item;

	huffman_code_bit_packer_top u_dut (
		.clk,
		.arst_n,
		.code_valid,
		.code_stall,
		.code_item,
		.pack_valid,
		.pack_stall,
		.pack_item
	);

	// Stimulus and expected bytes
	code_req_t      pending[$];
	out_beat_t      exp_bytes[$];
	bit             gen_loaded[SYMBOL_COUNT_DEF];
	logic [SYM_W-1:0] loaded_syms[$];
	idle_phase_t    gen_phase = PH_RX_SLOW;
	bit             gen_drain = 1'b0;
	bit             gen_hold  = 1'b0;

	// Packer state mirrored by the bench
	int               code_len_tbl[SYMBOL_COUNT_DEF];
	logic [CODE_W-1:0] code_bits_tbl[SYMBOL_COUNT_DEF];
	logic [ACC_W-1:0] pend_bits  = '0;
	int               pend_count = 0;

	// Pacing
	int unsigned tx_idle_pct = 30;
	int unsigned rx_idle_pct = 63;
	int unsigned hold_reqs   = 0;
	int unsigned holds_done  = 0;
	int unsigned hold_left   = 0;
	bit          code_taken  = 1'b0;

	// Bookkeeping
	int beats_total = 0;
	int beats_in    = 0;
	int bytes_seen  = 0;
	int mismatches  = 0;
	int quiet       = 0;
	int n_load = 0, n_encode = 0, n_flush = 0, n_reserved = 0, n_quad = 0;

	function automatic logic [63:0] low_ones(input int n);
		return (64'd1 << n) - 64'd1;
	endfunction

	// Bit packer: updates the table and accumulator, queues the bytes one beat yields
	task automatic predict_bytes(input in_beat_t b);
		logic [63:0] acc_val;
		logic [63:0] shifted;
		int len;
		int total;
		int nbytes;
		out_beat_t r;
		case (b.command)
			CMD_LOAD: begin
				len = b.code_length;
				if (len > CODE_CAP)
					len = CODE_CAP;
				code_len_tbl[b.symbol] = len;
				acc_val = {32'd0, b.code_bits} & low_ones(len);
				code_bits_tbl[b.symbol] = acc_val[CODE_W-1:0];
				n_load++;
			end
			CMD_ENCODE: begin
				len = code_len_tbl[b.symbol];
				acc_val = ({57'd0, pend_bits} << len) | {32'd0, code_bits_tbl[b.symbol]};
				total = pend_count + len;
				nbytes = total / 8;
				for (int k = 0; k < nbytes; k++) begin
					shifted = acc_val >> (total - 8 * (k + 1));
					r.out_byte = shifted[BYTE_W-1:0];
					r.last = (k == nbytes - 1);
					exp_bytes.push_back(r);
				end
				total = total % 8;
				shifted = acc_val & low_ones(total);
				pend_bits = shifted[ACC_W-1:0];
				pend_count = total;
				n_encode++;
				if (nbytes == 4)
					n_quad++;
			end
			CMD_FLUSH: begin
				// partial byte padded with zeros on the right
				if (pend_count != 0) begin
					shifted = {57'd0, pend_bits} << (8 - pend_count);
					r.out_byte = shifted[BYTE_W-1:0];
					r.last = 1'b1;
					exp_bytes.push_back(r);
					pend_bits = '0;
					pend_count = 0;
				end
				n_flush++;
			end
			default: n_reserved++;
		endcase
	endtask

	task automatic queue_beat(input logic [CMD_W-1:0] cmd, input logic [SYM_W-1:0] sym,
			input logic [CODE_W-1:0] bits, input logic [LEN_W-1:0] len);
		code_req_t r;
		r.beat.command = cmd;
		r.beat.symbol = sym;
		r.beat.code_bits = bits;
		r.beat.code_length = len;
		r.phase = gen_phase;
		r.drain = gen_drain;
		r.hold = gen_hold;
		gen_drain = 1'b0;
		gen_hold = 1'b0;
		pending.push_back(r);
		beats_total++;
		if (cmd == CMD_LOAD && !gen_loaded[sym]) begin
			gen_loaded[sym] = 1'b1;
			loaded_syms.push_back(sym);
		end
	endtask

	// Mostly encodes of loaded symbols, with reloads, flushes and a little noise
	task automatic queue_random(input int count);
		int pick;
		logic [SYM_W-1:0] sym;
		logic [LEN_W-1:0] len;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			if (pick < 60) begin
				sym = loaded_syms[$urandom_range(loaded_syms.size() - 1)];
				queue_beat(CMD_ENCODE, sym, $urandom, LEN_W'($urandom_range(63)));
			end else if (pick < 82) begin
				len = ($urandom_range(9) == 0) ? LEN_W'($urandom_range(63)) :
					LEN_W'($urandom_range(32, 1));
				queue_beat(CMD_LOAD, SYM_W'($urandom_range(255)), $urandom, len);
			end else if (pick < 96) begin
				queue_beat(CMD_FLUSH, SYM_W'($urandom_range(255)), $urandom,
					LEN_W'($urandom_range(63)));
			end else begin
				queue_beat(CMD_RESERVED, SYM_W'($urandom_range(255)), $urandom,
					LEN_W'($urandom_range(63)));
			end
		end
	endtask

	// Clock
	initial begin
		forever #5 clk = ~clk;
	end

	// Stimulus, reset and end of run
	initial begin
		// directed: zero, short, full and overlong lengths, stray bits above the length
		queue_beat(CMD_LOAD, 8'd0, 32'hFFFF_FFFF, 6'd0);
		queue_beat(CMD_LOAD, 8'd255, 32'hA5A5_3C3C, 6'd32);
		queue_beat(CMD_LOAD, 8'd1, 32'h0000_0001, 6'd1);
		queue_beat(CMD_LOAD, 8'd2, 32'h8000_0001, 6'd63);
		queue_beat(CMD_LOAD, 8'd3, 32'hFFFF_FFFD, 6'd3);
		queue_beat(CMD_LOAD, 8'd4, 32'h0000_0055, 6'd7);
		queue_beat(CMD_LOAD, 8'd5, 32'h0000_00C3, 6'd8);
		queue_beat(CMD_FLUSH, 8'd0, 32'd0, 6'd0);          // nothing pending
		queue_beat(CMD_ENCODE, 8'd0, 32'd0, 6'd0);         // zero-length code
		queue_beat(CMD_ENCODE, 8'd1, 32'hFFFF_FFFF, 6'd63); // one bit, no byte
		queue_beat(CMD_ENCODE, 8'd255, 32'd0, 6'd0);
		queue_beat(CMD_ENCODE, 8'd4, 32'd0, 6'd0);
		queue_beat(CMD_ENCODE, 8'd3, 32'd0, 6'd0);
		queue_beat(CMD_FLUSH, 8'd0, 32'd0, 6'd0);
		queue_beat(CMD_RESERVED, 8'hFF, 32'hFFFF_FFFF, 6'd63);
		queue_beat(CMD_ENCODE, 8'd2, 32'd0, 6'd0);
		queue_beat(CMD_ENCODE, 8'd5, 32'd0, 6'd0);
		queue_beat(CMD_LOAD, 8'd128, 32'hFFFF_FFFF, 6'd33);
		queue_beat(CMD_ENCODE, 8'd128, 32'd0, 6'd0);
		queue_beat(CMD_FLUSH, 8'd0, 32'd0, 6'd0);
		// seven bits pending, then a 32-bit code: four bytes from one beat
		queue_beat(CMD_ENCODE, 8'd4, 32'd0, 6'd0);
		queue_beat(CMD_ENCODE, 8'd255, 32'd0, 6'd0);
		queue_beat(CMD_FLUSH, 8'd0, 32'd0, 6'd0);
		queue_beat(CMD_ENCODE, 8'd1, 32'd0, 6'd0);
		queue_beat(CMD_FLUSH, 8'd0, 32'd0, 6'd0);

		queue_random(40);
		gen_phase = PH_TX_SLOW;
		gen_drain = 1'b1;
		queue_random(35);
		gen_phase = PH_FULL_RATE;
		gen_drain = 1'b1;
		queue_random(5);
		gen_hold = 1'b1;
		queue_random(25);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (beats_in != beats_total)
			@(posedge clk);
		while (exp_bytes.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("covered %0d beats: %0d loads, %0d encodes (%0d of four bytes), %0d flushes",
			beats_in, n_load, n_encode, n_quad, n_flush);
		$display("plus %0d reserved commands; %0d packed bytes checked, %0d mismatches",
			n_reserved, bytes_seen, mismatches);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Input driver: holds a stalled beat, otherwise idles or offers the next one
	always @(negedge clk) begin : drive
		code_req_t head;
		if (arst_n) begin
			if (!code_valid || code_taken) begin
				if (pending.size() == 0) begin
					code_valid <= 1'b0;
				end else begin
					head = pending[0];
					if ((head.drain && exp_bytes.size() != 0) ||
							$urandom_range(99) < tx_idle_pct) begin
						code_valid <= 1'b0;
					end else begin
						void'(pending.pop_front());
						code_item <= head.beat;
						code_valid <= 1'b1;
						case (head.phase)
							PH_RX_SLOW: begin
								tx_idle_pct = 30;
								rx_idle_pct <= 63;
							end
							PH_TX_SLOW: begin
								tx_idle_pct = 63;
								rx_idle_pct <= 30;
							end
							default: begin
								tx_idle_pct = 0;
								rx_idle_pct <= 0;
							end
						endcase
						if (head.hold)
							hold_reqs <= hold_reqs + 1;
					end
				end
			end
		end
	end

	// Byte receiver: random stall, or a long hold-off counted here
	always @(negedge clk) begin
		if (hold_left != 0) begin
			pack_stall <= 1'b1;
			hold_left--;
		end else if (holds_done != hold_reqs) begin
			holds_done++;
			hold_left = HOLD_CYCLES - 1;
			pack_stall <= 1'b1;
		end else begin
			pack_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	// Monitor: check output bytes, predict from accepted input beats, watchdog
	always @(posedge clk) begin : monitor
		out_beat_t want;
		if (arst_n) begin
			if (pack_valid && !pack_stall) begin
				bytes_seen++;
				if (exp_bytes.size() == 0) begin
					mismatches++;
					$display("%0t unexpected byte: expected none, got byte %h last %b",
						$time, pack_item.out_byte, pack_item.last);
				end else begin
					want = exp_bytes.pop_front();
					if (pack_item.out_byte !== want.out_byte) begin
						mismatches++;
						$display("%0t out_byte: expected %h, got %h",
							$time, want.out_byte, pack_item.out_byte);
					end
					if (pack_item.last !== want.last) begin
						mismatches++;
						$display("%0t last: expected %b, got %b", $time, want.last, pack_item.last);
					end
				end
			end
			code_taken = code_valid && !code_stall;
			if (code_taken) begin
				beats_in++;
				predict_bytes(code_item);
			end
			if (code_taken || (pack_valid && !pack_stall))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("%0t no beat moved for %0d cycles, %0d of %0d input beats taken",
					$time, quiet, beats_in, beats_total);
				$display("TB_ERROR");
				$finish;
			end
		end
	end

endmodule
